// ===== design/imu_scf_pkg.sv =====
// Package for the IMU sample correction and filter block.
// Holds the configuration register index codes and fixed constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package imu_scf_pkg;

  // Configuration register index width and codes
  localparam int CFG_INDEX_W = 3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MATRIX_ROW_X   = 3'd0,
    REG_MATRIX_ROW_Y   = 3'd1,
    REG_MATRIX_ROW_Z   = 3'd2,
    REG_ACCEL_OFFSET_X = 3'd3,
    REG_ACCEL_OFFSET_Y = 3'd4,
    REG_ACCEL_OFFSET_Z = 3'd5,
    REG_GYRO_DEADBAND  = 3'd6
  } cfg_index_t;

  // Accelerometer clamp limit and the signed width that holds it
  localparam int ACCEL_LIMIT = 8192;
  localparam int CLAMP_W     = 15;

  // Gyro deadband register width
  localparam int DEADBAND_W  = 15;

  // Integer bits of a Q3.x coefficient
  localparam int COEF_INT_BITS = 3;

endpackage

`default_nettype wire

// ===== design/imu_sample_correct_and_filter.sv =====
// IMU sample correction and filter: cross-axis matrix, offsets, gyro low-pass
// with deadband and temperature smoothing. Depends on imu_scf_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake             Payload
// -------   -------------------   ------------------------------------------
// in        in_valid / in_ready   raw_accel_x/y/z, raw_temperature, raw_gyro_x/y/z
// out       out_valid / out_ready accel_x/y/z_out, gyro_x/y/z_out, temperature_out
// cfg       cfg_write             cfg_index, cfg_data (no read-back)
//
// Each item passes through the input register and then the result register;
// one item per clock is sustained while out_ready stays high.
// The rate is set by the filter state loop, which runs from the state registers
// back to them through the constant-reciprocal divides by 10 and by 100.
// rst (synchronous) clears valids and filter states and sets config registers to defaults.
// While a waiting result sees out_ready low the input register holds, and
// in_ready drops once that register holds an item.

module imu_sample_correct_and_filter #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int COEF_WIDTH   = 18
) (
  input  wire                                   clk,
  input  wire                                   rst,

  input  wire                                   in_valid,
  output logic                                  in_ready,
  input  wire  signed [SAMPLE_WIDTH-1:0]        raw_accel_x,
  input  wire  signed [SAMPLE_WIDTH-1:0]        raw_accel_y,
  input  wire  signed [SAMPLE_WIDTH-1:0]        raw_accel_z,
  input  wire  signed [SAMPLE_WIDTH-1:0]        raw_temperature,
  input  wire  signed [SAMPLE_WIDTH-1:0]        raw_gyro_x,
  input  wire  signed [SAMPLE_WIDTH-1:0]        raw_gyro_y,
  input  wire  signed [SAMPLE_WIDTH-1:0]        raw_gyro_z,

  output logic                                  out_valid,
  input  wire                                   out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]        accel_x_out,
  output logic signed [SAMPLE_WIDTH-1:0]        accel_y_out,
  output logic signed [SAMPLE_WIDTH-1:0]        accel_z_out,
  output logic signed [SAMPLE_WIDTH-1:0]        gyro_x_out,
  output logic signed [SAMPLE_WIDTH-1:0]        gyro_y_out,
  output logic signed [SAMPLE_WIDTH-1:0]        gyro_z_out,
  output logic signed [SAMPLE_WIDTH-1:0]        temperature_out,

  input  wire                                   cfg_write,
  input  wire  [imu_scf_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire  [3*COEF_WIDTH-1:0]               cfg_data
);

  localparam int SW   = SAMPLE_WIDTH;
  localparam int CW   = COEF_WIDTH;
  localparam int RW   = 3 * CW;
  localparam int FRAC = CW - imu_scf_pkg::COEF_INT_BITS;
  localparam int LW   = imu_scf_pkg::CLAMP_W;

  // Clamp compare width
  localparam int EXT_W = (SW > LW) ? SW : LW;
  // Matrix product, row sum and truncated quotient widths
  localparam int PRW = LW + CW;
  localparam int PW  = PRW + 2;
  localparam int QW  = PW - FRAC;
  // Saturation input width covers every value that gets saturated
  localparam int SATW = ((QW > SW + 1) ? QW : SW + 1) + 1;
  // Deadband compare width
  localparam int DBW = (SW > imu_scf_pkg::DEADBAND_W) ? SW : imu_scf_pkg::DEADBAND_W;

  // Gyro divide by 10: numerator width, magnitude width, reciprocal shift
  localparam int GN  = SW + 5;
  localparam int N_G = SW + 3;
  localparam int S_G = N_G + 4;
  // Temperature divide by 100
  localparam int TN  = SW + 7;
  localparam int N_T = SW + 6;
  localparam int S_T = N_T + 7;

  localparam logic [63:0] ONE64       = 64'd1;
  localparam logic [63:0] RECIP_G_ALL = ((ONE64 << S_G) + 64'd9) / 64'd10;
  localparam logic [63:0] RECIP_T_ALL = ((ONE64 << S_T) + 64'd99) / 64'd100;
  localparam logic [N_G:0] RECIP_G    = RECIP_G_ALL[N_G:0];
  localparam logic [N_T:0] RECIP_T    = RECIP_T_ALL[N_T:0];

  localparam logic signed [EXT_W-1:0] CLAMP_HI = EXT_W'(imu_scf_pkg::ACCEL_LIMIT);
  localparam logic signed [EXT_W-1:0] CLAMP_LO = -CLAMP_HI;
  localparam logic signed [SATW-1:0]  SAT_HI   = SATW'((1 << (SW - 1)) - 1);
  localparam logic signed [SATW-1:0]  SAT_LO   = -SAT_HI - SATW'(1);
  localparam logic signed [PW-1:0]    TRUNC_ADJ = PW'((1 << FRAC) - 1);

  localparam logic [RW-1:0] ROW_X_RESET = RW'(ONE64 << FRAC);
  localparam logic [RW-1:0] ROW_Y_RESET = RW'(ONE64 << (FRAC + CW));
  localparam logic [RW-1:0] ROW_Z_RESET = RW'(ONE64 << (FRAC + 2 * CW));

  // Saturate to the sample range
  function automatic logic signed [SW-1:0] sat_sample(input logic signed [SATW-1:0] v);
    logic signed [SW-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[SW-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[SW-1:0];
    end else begin
      r = v[SW-1:0];
    end
    return r;
  endfunction

  // Configuration registers
  logic        [RW-1:0]                         row [3];
  logic signed [SW-1:0]                         offset [3];
  logic        [imu_scf_pkg::DEADBAND_W-1:0]    deadband;

  // Input register
  logic                 s1_valid;
  logic signed [SW-1:0] s1_accel [3];
  logic signed [SW-1:0] s1_gyro [3];
  logic signed [SW-1:0] s1_temp;

  // Filter state
  logic signed [SW-1:0] gyro_state [3];
  logic signed [SW-1:0] temp_state;

  // Result register
  logic signed [SW-1:0] out_accel [3];
  logic signed [SW-1:0] out_gyro [3];
  logic signed [SW-1:0] out_temp;

  // Combinational results
  logic signed [SW-1:0] accel_next [3];
  logic signed [SW-1:0] gyro_next [3];
  logic signed [SW-1:0] temp_next;

  logic in_take;
  logic s1_advance;
  logic s1_load;
  logic s1_valid_next;
  logic out_valid_next;

  // Handshake control
  assign s1_advance     = !out_valid || out_ready;
  assign in_ready       = !s1_valid || s1_advance;
  assign in_take        = in_valid && in_ready;
  assign s1_load        = s1_valid && s1_advance;
  assign s1_valid_next  = in_take || (s1_valid && !s1_advance);
  assign out_valid_next = s1_load || (out_valid && !out_ready);

  // Write configuration registers; ignore unknown indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      row[0]    <= ROW_X_RESET;
      row[1]    <= ROW_Y_RESET;
      row[2]    <= ROW_Z_RESET;
      offset[0] <= '0;
      offset[1] <= '0;
      offset[2] <= '0;
      deadband  <= '0;
    end else if (cfg_write) begin
      case (imu_scf_pkg::cfg_index_t'(cfg_index))
        imu_scf_pkg::REG_MATRIX_ROW_X:   row[0]    <= cfg_data;
        imu_scf_pkg::REG_MATRIX_ROW_Y:   row[1]    <= cfg_data;
        imu_scf_pkg::REG_MATRIX_ROW_Z:   row[2]    <= cfg_data;
        imu_scf_pkg::REG_ACCEL_OFFSET_X: offset[0] <= cfg_data[SW-1:0];
        imu_scf_pkg::REG_ACCEL_OFFSET_Y: offset[1] <= cfg_data[SW-1:0];
        imu_scf_pkg::REG_ACCEL_OFFSET_Z: offset[2] <= cfg_data[SW-1:0];
        imu_scf_pkg::REG_GYRO_DEADBAND:  deadband  <= cfg_data[imu_scf_pkg::DEADBAND_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid  <= s1_valid_next;
      out_valid <= out_valid_next;
    end
  end

  // Capture an accepted item
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_accel[0] <= raw_accel_x;
      s1_accel[1] <= raw_accel_y;
      s1_accel[2] <= raw_accel_z;
      s1_gyro[0]  <= raw_gyro_x;
      s1_gyro[1]  <= raw_gyro_y;
      s1_gyro[2]  <= raw_gyro_z;
      s1_temp     <= raw_temperature;
    end
  end

  // Clamp the accelerometer axes to the limit
  logic signed [LW-1:0] accel_clamp [3];

  for (genvar a = 0; a < 3; a++) begin : g_clamp
    logic signed [EXT_W-1:0] ext;
    assign ext = EXT_W'(s1_accel[a]);
    assign accel_clamp[a] = (ext > CLAMP_HI) ? CLAMP_HI[LW-1:0] :
                            (ext < CLAMP_LO) ? CLAMP_LO[LW-1:0] : ext[LW-1:0];
  end

  // Cross-axis product, truncate toward zero, saturate, remove offset
  for (genvar a = 0; a < 3; a++) begin : g_accel
    logic signed [PRW-1:0] p0;
    logic signed [PRW-1:0] p1;
    logic signed [PRW-1:0] p2;
    logic signed [PW-1:0]  acc;
    logic signed [PW-1:0]  acc_adj;
    logic signed [QW-1:0]  q;
    logic signed [SW-1:0]  corr;

    assign p0      = accel_clamp[0] * $signed(row[a][0 +: CW]);
    assign p1      = accel_clamp[1] * $signed(row[a][CW +: CW]);
    assign p2      = accel_clamp[2] * $signed(row[a][2*CW +: CW]);
    assign acc     = PW'(p0) + PW'(p1) + PW'(p2);
    assign acc_adj = acc[PW-1] ? acc + TRUNC_ADJ : acc;
    assign q       = acc_adj[PW-1:FRAC];
    assign corr    = sat_sample(SATW'(q));
    assign accel_next[a] = sat_sample(SATW'(corr) - SATW'(offset[a]));
  end

  // Gyro low-pass (prev + 9*data)/10 toward zero, then deadband
  for (genvar g = 0; g < 3; g++) begin : g_gyro
    logic signed [GN-1:0]   d_ext;
    logic signed [GN-1:0]   num;
    logic signed [GN-1:0]   num_abs;
    logic        [N_G-1:0]  mag_in;
    logic        [2*N_G:0]  prod;
    logic        [SW-1:0]   quo;
    logic signed [SW:0]     quo_s;
    logic signed [SW-1:0]   val;
    logic        [SW-1:0]   mag;

    assign d_ext   = GN'(s1_gyro[g]);
    assign num     = (d_ext <<< 3) + d_ext + GN'(gyro_state[g]);
    assign num_abs = num[GN-1] ? -num : num;
    assign mag_in  = num_abs[N_G-1:0];
    assign prod    = mag_in * RECIP_G;
    assign quo     = prod[S_G +: SW];
    assign quo_s   = num[GN-1] ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    assign val     = sat_sample(SATW'(quo_s));
    assign mag     = val[SW-1] ? SW'(-val) : SW'(val);
    assign gyro_next[g] = (DBW'(mag) < DBW'(deadband)) ? '0 : val;
  end

  // Temperature smoothing (99*prev + data)/100 toward zero
  logic signed [TN-1:0]  t_prev;
  logic signed [TN-1:0]  t_num;
  logic signed [TN-1:0]  t_abs;
  logic        [N_T-1:0] t_mag;
  logic        [2*N_T:0] t_prod;
  logic        [SW-1:0]  t_quo;
  logic signed [SW:0]    t_quo_s;

  assign t_prev  = TN'(temp_state);
  assign t_num   = (t_prev <<< 6) + (t_prev <<< 5) + (t_prev <<< 1) + t_prev + TN'(s1_temp);
  assign t_abs   = t_num[TN-1] ? -t_num : t_num;
  assign t_mag   = t_abs[N_T-1:0];
  assign t_prod  = t_mag * RECIP_T;
  assign t_quo   = t_prod[S_T +: SW];
  assign t_quo_s = t_num[TN-1] ? -$signed({1'b0, t_quo}) : $signed({1'b0, t_quo});
  assign temp_next = sat_sample(SATW'(t_quo_s));

  // Advance filter state with each item moved to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      gyro_state[0] <= '0;
      gyro_state[1] <= '0;
      gyro_state[2] <= '0;
      temp_state    <= '0;
    end else if (s1_load) begin
      gyro_state[0] <= gyro_next[0];
      gyro_state[1] <= gyro_next[1];
      gyro_state[2] <= gyro_next[2];
      temp_state    <= temp_next;
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (s1_load) begin
      out_accel[0] <= accel_next[0];
      out_accel[1] <= accel_next[1];
      out_accel[2] <= accel_next[2];
      out_gyro[0]  <= gyro_next[0];
      out_gyro[1]  <= gyro_next[1];
      out_gyro[2]  <= gyro_next[2];
      out_temp     <= temp_next;
    end
  end

  assign accel_x_out     = out_accel[0];
  assign accel_y_out     = out_accel[1];
  assign accel_z_out     = out_accel[2];
  assign gyro_x_out      = out_gyro[0];
  assign gyro_y_out      = out_gyro[1];
  assign gyro_z_out      = out_gyro[2];
  assign temperature_out = out_temp;

endmodule

`default_nettype wire
